/* sv/pfbi_pkg.sv */
// Package with the shared types and constants of the prime-field batch inverter.
`timescale 1ns / 1ps
package pfbi_pkg;
    localparam int VW = 13;
    localparam int PW = 6;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          last;
    } t_item;
endpackage

/* sv/prime_field_batch_inverse.sv */
// Top level of the prime-field batch inverter.
//
// Usage: present an element on i_value with i_last marking the final element
// of a batch and raise start; the transfer takes place at an edge where start
// is high and busy is low. The front end reduces each value modulo the prime
// by reciprocal multiplication, first the quotient and then the remainder,
// and hands it to a two-entry queue, waiting while the queue is full; busy
// stays high from each transfer until the item enters the queue. The back
// end uses one bit-serial multiplier; each element after the first of a batch
// is multiplied into the prefix product. When a batch closes (i_last, or the
// store full) the final product is raised to the power MODULUS-2 by square
// and multiply (25 products for 8191), then the backward walk takes two
// products per element after the first, after which the inverses leave in
// input order, each marked by o_valid for one cycle with its position and
// o_final_res on the last. A batch holding a zero element gives a single
// result with o_error set. The receiver cannot stall.
// Synchronous reset empties the queue and the open batch; the stores are not
// cleared, as entries are always written before they are read.
`timescale 1ns / 1ps
module prime_field_batch_inverse import pfbi_pkg::*; #(
    parameter int MODULUS   = 8191,
    parameter int MAX_BATCH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [VW-1:0] i_value,
    input  logic          i_last,
    output logic          o_valid,
    output logic [VW-1:0] o_inverse,
    output logic [PW-1:0] o_position,
    output logic          o_final_res,
    output logic          o_error
);
    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item f_item;
    t_item q_item;

    pfbi_front #(.MODULUS(MODULUS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_value (i_value),
        .i_last  (i_last),
        .o_busy  (busy),
        .o_push  (push),
        .o_item  (f_item),
        .i_full  (full)
    );

    pfbi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    pfbi_back #(.MODULUS(MODULUS), .MAX_BATCH(MAX_BATCH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_inverse   (o_inverse),
        .o_position  (o_position),
        .o_final_res (o_final_res),
        .o_error     (o_error)
    );

    // An error result is always the sole, final result with zero payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_final_res && o_inverse == '0 && o_position == '0)
        else $error("malformed error result");

    // Every inverse is a reduced residue.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (14)'(o_inverse) < (14)'(MODULUS))
        else $error("inverse not reduced");

    // Results never come in consecutive cycles.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");

    // The queue is never pushed when full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue overflow");
endmodule

/* sv/pfbi_mul.sv */
// Bit-serial modular multiplier, one bit of the second operand per cycle.
`timescale 1ns / 1ps
module pfbi_mul import pfbi_pkg::*; #(
    parameter int MODULUS = 8191
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_a,
    input  logic [VW-1:0] i_b,
    output logic          o_done,
    output logic [VW-1:0] o_product
);
    localparam logic [VW+1:0] M = (VW+2)'(MODULUS);

    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_k;
    logic [VW-1:0] r_a;
    logic [VW-1:0] r_b;
    logic [VW-1:0] r_acc;
    logic [VW+1:0] dbl;
    logic [VW+1:0] dbl_red;
    logic [VW+1:0] sum;
    logic [VW+1:0] sum_red;

    // One interleaved step: double, reduce, add the operand if the bit is set, reduce.
    always_comb begin
        dbl     = {1'b0, r_acc, 1'b0};
        dbl_red = (dbl >= M) ? dbl - M : dbl;
        sum     = dbl_red + (r_b[r_k] ? {2'b00, r_a} : '0);
        sum_red = (sum >= M) ? sum - M : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_k    <= 4'(VW - 1);
            end else if (r_busy) begin
                r_acc  <= sum_red[VW-1:0];
                r_k    <= r_k - 4'd1;
                r_done <= (r_k == 4'd0);
                if (r_k == 4'd0) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;
endmodule

/* sv/pfbi_front.sv */
// Front end: accepts an item and reduces its value modulo the prime by reciprocal multiplication.
`timescale 1ns / 1ps
module pfbi_front import pfbi_pkg::*; #(
    parameter int MODULUS = 8191
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [VW-1:0] i_value,
    input  logic          i_last,
    output logic          o_busy,
    output logic          o_push,
    output t_item         o_item,
    input  logic          i_full
);
    // Rounded-up reciprocal scaled by 2^(2*VW); exact quotient for every VW-bit value.
    localparam logic [2*VW-1:0] RECIP =
        (2*VW)'(((1 << (2*VW)) + MODULUS - 1) / MODULUS);
    localparam logic [VW-1:0] M = VW'(MODULUS);

    logic            r_hold;
    logic            r_done;
    logic            r_phase;
    logic [VW-1:0]   r_r;
    logic [VW-1:0]   r_q;
    logic            r_last;
    logic [3*VW-1:0] quot_full;
    logic [2*VW-1:0] back_mul;

    assign quot_full = (3*VW)'(r_r) * (3*VW)'(RECIP);
    assign back_mul  = (2*VW)'(r_q) * (2*VW)'(M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start && !r_hold) begin
                // Take the transfer and begin the reduction.
                r_hold  <= 1'b1;
                r_done  <= 1'b0;
                r_phase <= 1'b0;
                r_r     <= i_value;
                r_last  <= i_last;
            end else if (r_hold && !r_done) begin
                // First the quotient, then the remainder.
                if (!r_phase) begin
                    r_q     <= quot_full[3*VW-1:2*VW];
                    r_phase <= 1'b1;
                end else begin
                    r_r    <= r_r - back_mul[VW-1:0];
                    r_done <= 1'b1;
                end
            end else if (r_hold && r_done && !i_full) begin
                r_hold <= 1'b0;
            end
        end
    end

    assign o_busy       = r_hold;
    assign o_push       = r_hold && r_done && !i_full;
    assign o_item.value = r_r;
    assign o_item.last  = r_last;
endmodule

/* sv/pfbi_queue.sv */
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module pfbi_queue import pfbi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
endmodule

/* sv/pfbi_back.sv */
// Back end: prefix products, Fermat inversion, backward walk and ordered emission.
`timescale 1ns / 1ps
module pfbi_back import pfbi_pkg::*; #(
    parameter int MODULUS   = 8191,
    parameter int MAX_BATCH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_item         i_item,
    output logic          o_pop,
    output logic          o_valid,
    output logic [VW-1:0] o_inverse,
    output logic [PW-1:0] o_position,
    output logic          o_final_res,
    output logic          o_error
);
    localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
    localparam int CW = $clog2(MAX_BATCH + 1);
    localparam logic [VW-1:0] EXP = VW'(MODULUS - 2);

    typedef enum logic [3:0] {
        S_IDLE, S_PMUL, S_WR, S_PSQ, S_PMP, S_WRD, S_WMA, S_WMB, S_W0, S_ERD, S_EMIT, S_ERR
    } t_state;

    t_state        r_state;
    logic          r_wait;
    logic [CW-1:0] r_count;
    logic          r_zero;
    logic [VW-1:0] r_v;
    logic          r_last;
    logic [VW-1:0] r_p;
    logic [VW-1:0] r_acc;
    logic [VW-1:0] r_inv;
    logic [3:0]    r_k;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_n1;
    logic [VW-1:0] r_elem [MAX_BATCH];
    logic [VW-1:0] r_pre  [MAX_BATCH];
    logic [VW-1:0] r_erd;
    logic [VW-1:0] r_prd;

    logic          mul_start;
    logic          mul_done;
    logic [VW-1:0] mul_a;
    logic [VW-1:0] mul_b;
    logic [VW-1:0] mul_p;
    logic          e_we;
    logic [AW-1:0] e_wa;
    logic [VW-1:0] e_wd;
    logic [AW-1:0] idx;

    assign idx = r_count[AW-1:0];

    pfbi_mul #(.MODULUS(MODULUS)) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    // Operand selection and start strobe for the shared multiplier.
    always_comb begin
        mul_a     = r_acc;
        mul_b     = r_acc;
        mul_start = 1'b0;
        case (r_state)
            S_PMUL: begin
                mul_a     = r_p;
                mul_b     = r_v;
                mul_start = !r_wait && (r_count != '0);
            end
            S_PSQ: mul_start = !r_wait;
            S_PMP: begin
                mul_b     = r_p;
                mul_start = !r_wait;
            end
            S_WMA: begin
                mul_b     = r_prd;
                mul_start = !r_wait;
            end
            S_WMB: begin
                mul_b     = r_erd;
                mul_start = !r_wait;
            end
            default: ;
        endcase
    end

    // Element store write port, shared by loading, the walk and the final inverse.
    always_comb begin
        e_we = 1'b0;
        e_wa = idx;
        e_wd = r_v;
        case (r_state)
            S_WR: e_we = 1'b1;
            S_WMB: begin
                e_we = r_wait && mul_done;
                e_wa = r_i;
                e_wd = r_inv;
            end
            S_W0: begin
                e_we = 1'b1;
                e_wa = '0;
                e_wd = r_acc;
            end
            default: ;
        endcase
    end

    // Stores with registered reads.
    always_ff @(posedge i_clk) begin
        if (e_we) begin
            r_elem[e_wa] <= e_wd;
        end
        if (r_state == S_WR) begin
            r_pre[idx] <= r_p;
        end
        r_erd <= r_elem[r_i];
        r_prd <= r_pre[r_i - AW'(1)];
    end

    assign o_pop = (r_state == S_IDLE) && i_valid;

    // Sequencer with registered result outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_count <= '0;
            r_zero  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_EMIT) || (r_state == S_ERR);
            if (mul_start) begin
                r_wait <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_v     <= i_item.value;
                        r_last  <= i_item.last;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (r_count == '0) begin
                        r_p     <= r_v;
                        r_state <= S_WR;
                    end else if (r_wait && mul_done) begin
                        r_wait  <= 1'b0;
                        r_p     <= mul_p;
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_last || r_count == CW'(MAX_BATCH - 1)) begin
                        r_n1 <= idx;
                        r_i  <= idx;
                        if (r_zero || r_v == '0) begin
                            r_state <= S_ERR;
                        end else begin
                            r_acc   <= VW'(1);
                            r_k     <= 4'(VW - 1);
                            r_state <= S_PSQ;
                        end
                    end else begin
                        r_zero  <= r_zero || (r_v == '0);
                        r_count <= r_count + CW'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_PSQ, S_PMP: begin
                    if (r_wait && mul_done) begin
                        r_wait <= 1'b0;
                        r_acc  <= mul_p;
                        if (r_state == S_PSQ && EXP[r_k]) begin
                            r_state <= S_PMP;
                        end else if (r_k == 4'd0) begin
                            r_state <= (r_i == '0) ? S_W0 : S_WRD;
                        end else begin
                            r_k     <= r_k - 4'd1;
                            r_state <= S_PSQ;
                        end
                    end
                end
                S_WRD: r_state <= S_WMA;
                S_WMA: begin
                    if (r_wait && mul_done) begin
                        r_wait  <= 1'b0;
                        r_inv   <= mul_p;
                        r_state <= S_WMB;
                    end
                end
                S_WMB: begin
                    if (r_wait && mul_done) begin
                        r_wait  <= 1'b0;
                        r_acc   <= mul_p;
                        r_i     <= r_i - AW'(1);
                        r_state <= (r_i == AW'(1)) ? S_W0 : S_WRD;
                    end
                end
                S_W0: begin
                    r_i     <= '0;
                    r_state <= S_ERD;
                end
                S_ERD: r_state <= S_EMIT;
                S_EMIT: begin
                    o_inverse   <= r_erd;
                    o_position  <= PW'(r_i);
                    o_final_res <= (r_i == r_n1);
                    o_error     <= 1'b0;
                    if (r_i == r_n1) begin
                        r_count <= '0;
                        r_zero  <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_ERD;
                    end
                end
                S_ERR: begin
                    o_inverse   <= '0;
                    o_position  <= '0;
                    o_final_res <= 1'b1;
                    o_error     <= 1'b1;
                    r_count     <= '0;
                    r_zero      <= 1'b0;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* test/prime_field_batch_inverse_tb.sv */
// Self-checking testbench for the prime-field batch inverter.
`timescale 1ns / 1ps
module prime_field_batch_inverse_tb;
    import pfbi_pkg::*;

    localparam int PRIME      = 8191;
    localparam int STORE_SIZE = 64;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 2000;

    typedef struct {
        logic [VW-1:0] inverse;
        logic [PW-1:0] position;
        logic          final_res;
        logic          error;
    } t_inverse_res;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [VW-1:0] i_value;
    logic          i_last;
    logic          o_valid;
    logic [VW-1:0] o_inverse;
    logic [PW-1:0] o_position;
    logic          o_final_res;
    logic          o_error;

    // Predictor state for the open batch.
    int unsigned   held_elems [STORE_SIZE];
    int unsigned   held_prefix [STORE_SIZE];
    int unsigned   held_count;
    bit            zero_in_batch;
    t_inverse_res  pending_inverses[$];
    int            error_count;
    int            sender_idle_pct;
    int unsigned   cycle_count;

    prime_field_batch_inverse dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .o_inverse  (o_inverse),
        .o_position (o_position),
        .o_final_res(o_final_res),
        .o_error    (o_error)
    );

    // Clock of 20 ns period.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int unsigned mul_mod(int unsigned a, int unsigned b);
        longint unsigned p;
        p = longint'(a) * longint'(b);
        return int'(p % PRIME);
    endfunction

    // Fermat inverse: raise to the power PRIME-2 by square and multiply.
    function automatic int unsigned fermat_inverse(int unsigned x);
        int unsigned e;
        int unsigned acc;
        int unsigned sq;
        e   = PRIME - 2;
        acc = 1;
        sq  = x % PRIME;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, sq);
            sq = mul_mod(sq, sq);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // Takes one accepted element into the predictor and queues any inverses it releases.
    task automatic absorb_element(logic [VW-1:0] raw, logic is_last);
        int unsigned v;
        int unsigned idx;
        int unsigned n;
        int unsigned acc;
        int unsigned invs [STORE_SIZE];
        t_inverse_res r;
        v   = int'(raw) % PRIME;
        idx = (held_count >= STORE_SIZE) ? STORE_SIZE - 1 : held_count;
        held_elems[idx]  = v;
        held_prefix[idx] = (idx == 0) ? v : mul_mod(held_prefix[idx-1], v);
        if (v == 0) zero_in_batch = 1'b1;
        held_count = idx + 1;
        if (!is_last && held_count < STORE_SIZE) return;
        n = held_count;
        if (zero_in_batch) begin
            r.inverse   = '0;
            r.position  = '0;
            r.final_res = 1'b1;
            r.error     = 1'b1;
            pending_inverses.push_back(r);
        end else begin
            // Backward walk from the inverse of the whole product.
            acc = fermat_inverse(held_prefix[n-1]);
            for (int i = n - 1; i >= 1; i--) begin
                invs[i] = mul_mod(acc, held_prefix[i-1]);
                acc     = mul_mod(acc, held_elems[i]);
            end
            invs[0] = acc;
            for (int i = 0; i < n; i++) begin
                r.inverse   = invs[i][VW-1:0];
                r.position  = i[PW-1:0];
                r.final_res = (i == n - 1);
                r.error     = 1'b0;
                pending_inverses.push_back(r);
            end
        end
        held_count    = 0;
        zero_in_batch = 1'b0;
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Sends one element, possibly with a random idle gap before it, and waits for the transfer.
    task automatic send_element(logic [VW-1:0] v, logic is_last);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        i_last  <= is_last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        absorb_element(v, is_last);
        @(negedge i_clk);
    endtask

    // Waits until every expected inverse has come out, then lets the block settle.
    task automatic drain;
        start <= 1'b0;
        while (pending_inverses.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // Sends one batch of random elements, possibly with a zero among them.
    task automatic send_random_batch(int unsigned len, bit with_zero);
        int unsigned zpos;
        logic [VW-1:0] v;
        zpos = $urandom_range(len - 1);
        for (int unsigned k = 0; k < len; k++) begin
            v = VW'($urandom_range(8191));
            if (with_zero && k == zpos) v = $urandom_range(1) ? VW'(0) : VW'(PRIME);
            else if (v == 0 || v == PRIME) v = 1;
            send_element(v, k == len - 1);
        end
    endtask

    task automatic test_directed;
        sender_idle_pct = 0;
        // Single-element batches at the edges of the value range, then a batch of three.
        send_element(13'd1, 1'b1);
        send_element(13'd8190, 1'b1);
        send_element(13'd8189, 1'b1);
        send_element(13'h1FFF, 1'b1);                    // equal to the prime: counts as zero
        send_element(13'd0, 1'b1);                       // plain zero
        send_element(13'h1AAA, 1'b0);
        send_element(13'h0555, 1'b0);
        send_element(13'd2, 1'b1);
        // A zero in the middle of a batch suppresses every inverse.
        send_element(13'd7, 1'b0);
        send_element(13'd0, 1'b0);
        send_element(13'd9, 1'b1);
        // Values just below the prime within one batch.
        send_element(13'd8189, 1'b0);
        send_element(13'd8190, 1'b0);
        send_element(13'd4096, 1'b0);
        send_element(13'd1, 1'b1);
        drain();
    endtask

    task automatic test_random(int idle_pct, int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            // Beyond the store size, the store closes the batch by itself.
            if (len > STORE_SIZE) begin
                for (int unsigned k = 0; k < len; k++)
                    send_element(VW'($urandom_range(1, 8190)), k == len - 1);
            end else begin
                send_random_batch(len, $urandom_range(7) == 0);
            end
            sent += len;
        end
        drain();
    endtask

    // Compares each transfer on the result side with the oldest expectation.
    always @(posedge i_clk) begin
        t_inverse_res e;
        if (i_rst_n && o_valid) begin
            if (pending_inverses.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = pending_inverses.pop_front();
                if (o_inverse !== e.inverse)
                    report_mismatch($sformatf("inverse %0d, expected %0d", o_inverse, e.inverse));
                if (o_position !== e.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              o_position, e.position));
                if (o_final_res !== e.final_res)
                    report_mismatch($sformatf("final_res %0b, expected %0b",
                                              o_final_res, e.final_res));
                if (o_error !== e.error)
                    report_mismatch($sformatf("error %0b, expected %0b", o_error, e.error));
            end
        end
    end

    // Cycle counter with a generous limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("prime_field_batch_inverse_tb: done, errors");
            $finish;
        end
    end

    initial begin
        start         = 1'b0;
        i_value       = '0;
        i_last        = 1'b0;
        i_rst_n       = 1'b0;
        held_count    = 0;
        zero_in_batch = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        sender_idle_pct = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(0, 120);
        test_random(45, 120);
        test_random(25, 120);
        test_random(0, 100);

        if (pending_inverses.size() != 0 || error_count != 0) begin
            if (pending_inverses.size() != 0) report_mismatch("expected results left over");
            $display("prime_field_batch_inverse_tb: done, errors");
        end else begin
            $display("prime_field_batch_inverse_tb: done, clean");
        end
        $finish;
    end
endmodule
